// ----- sv/vsrbp_pkg.sv -----
// Shared types, constants and helpers for the vector shape record bit packer.
package vsrbp_pkg;

    localparam int COORD_W        = 16;
    localparam int COLOR_W        = 8;
    localparam int SCALE_W        = 10;
    localparam int FUNC_W         = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int SEG_LEN_W      = 4;
    localparam int IDX_W          = 6;
    localparam int NB_W           = 5;
    localparam int WIDE_W         = 29;
    localparam int FIFO_DEPTH_DEF = 4;

    localparam logic [FUNC_W-1:0] FUNC_LINE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POINT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_END   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_SHIFT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SHIFT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_TOP   = 2'd3;

    localparam logic [SCALE_W-1:0] SCALE_RST = 10'd1;

    typedef enum logic [1:0] {
        SEG_BITS,
        SEG_PAD,
        SEG_END
    } seg_kind_t;

    typedef struct packed {
        seg_kind_t            kind;
        logic [SEG_LEN_W-1:0] len;
        logic [7:0]           data;
    } seg_t;

    typedef struct packed {
        logic [SCALE_W-1:0]        scale;
        logic signed [COORD_W-1:0] x_shift;
        logic signed [COORD_W-1:0] y_shift;
        logic signed [COORD_W-1:0] y_top;
    } cfg_t;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [COORD_W-1:0] x_start;
        logic signed [COORD_W-1:0] y_start;
        logic signed [COORD_W-1:0] x_end;
        logic signed [COORD_W-1:0] y_end;
        logic [COLOR_W-1:0]        red;
        logic [COLOR_W-1:0]        green;
        logic [COLOR_W-1:0]        blue;
        logic [COLOR_W-1:0]        alpha;
    } item_t;

    function automatic logic signed [COORD_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > 29'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -29'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    function automatic seg_t mk_seg(input seg_kind_t k, input logic [SEG_LEN_W-1:0] l,
                                    input logic [7:0] d);
        seg_t s;
        s.kind = k;
        s.len  = l;
        s.data = d;
        return s;
    endfunction

endpackage

// ----- sv/vsrbp_in_if.sv -----
// Input channel: one drawing primitive per beat.
interface vsrbp_in_if
    import vsrbp_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic signed [COORD_W-1:0] x_start;
    logic signed [COORD_W-1:0] y_start;
    logic signed [COORD_W-1:0] x_end;
    logic signed [COORD_W-1:0] y_end;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
    logic [COLOR_W-1:0]        alpha;

    modport source (output valid, func, x_start, y_start, x_end, y_end,
                    red, green, blue, alpha, input ready);
    modport sink (input valid, func, x_start, y_start, x_end, y_end,
                  red, green, blue, alpha, output ready);
endinterface

// ----- sv/vsrbp_out_if.sv -----
// Output channel: one packed byte per beat.
interface vsrbp_out_if
    import vsrbp_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, out_byte, last, input ready);
    modport sink (input valid, out_byte, last, output ready);
endinterface

// ----- sv/vsrbp_seg_fifo.sv -----
// Segment queue between the primitive sequencer and the bit packer.
module vsrbp_seg_fifo
    import vsrbp_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  seg_t wr_seg,
    input  logic pop,
    output seg_t head,
    output logic full,
    output logic empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    seg_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_seg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

// ----- sv/vsrbp_front.sv -----
// Front end: input buffer, coordinate mapper and segment sequencer.
module vsrbp_front
    import vsrbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    vsrbp_in_if.sink   in_ch,
    output logic       push,
    output seg_t       seg,
    input  logic       full
);
    localparam logic [IDX_W-1:0] IDX_MAIN       = 6'd9;
    localparam logic [IDX_W-1:0] IDX_LINE_LAST  = 6'd33;
    localparam logic [IDX_W-1:0] IDX_POINT_LAST = 6'd34;
    localparam logic [2:0]       CCNT_DONE      = 3'd6;

    item_t                     buf_reg;
    item_t                     cur_reg;
    item_t                     in_item;
    logic                      buf_valid_reg;
    logic                      busy_reg;
    logic                      preamble_sent_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [2:0]                ccnt_reg;
    logic signed [COORD_W-1:0] xs_reg, ys_reg, xe_reg, ye_reg, dx_reg, dy_reg;
    logic [NB_W-1:0]           nb_reg;

    logic                      load;
    logic                      take;
    logic signed [COORD_W-1:0] coord, shift;
    logic                      is_y;
    logic signed [COORD_W:0]   diff;
    logic signed [27:0]        prod;
    logic signed [WIDE_W-1:0]  mapped_wide;
    logic signed [COORD_W-1:0] mapped;
    logic signed [COORD_W-1:0] dx_sat, dy_sat;
    logic [COORD_W:0]          dx_ext, dy_ext, dx_mag, dy_mag, mag_or;
    logic [NB_W-1:0]           bitlen, nb_calc;
    logic [COORD_W:0]          dxv, dyv;
    logic [SEG_LEN_W-1:0]      len_a, len_b, len_c, nbm2;
    logic                      is_end, is_line;
    logic [IDX_W-1:0]          last_idx;

    assign load         = buf_valid_reg && !busy_reg;
    assign in_ch.ready  = !buf_valid_reg || load;
    assign take         = in_ch.valid && in_ch.ready;

    always_comb
    begin
        in_item.func    = in_ch.func;
        in_item.x_start = in_ch.x_start;
        in_item.y_start = in_ch.y_start;
        in_item.x_end   = in_ch.x_end;
        in_item.y_end   = in_ch.y_end;
        in_item.red     = in_ch.red;
        in_item.green   = in_ch.green;
        in_item.blue    = in_ch.blue;
        in_item.alpha   = in_ch.alpha;
    end

    always_comb
    begin
        unique case (ccnt_reg[1:0])
            2'd0:
            begin
                coord = cur_reg.x_start;
                shift = cfg.x_shift;
                is_y  = 1'b0;
            end
            2'd1:
            begin
                coord = cur_reg.y_start;
                shift = cfg.y_shift;
                is_y  = 1'b1;
            end
            2'd2:
            begin
                coord = cur_reg.x_end;
                shift = cfg.x_shift;
                is_y  = 1'b0;
            end
            default:
            begin
                coord = cur_reg.y_end;
                shift = cfg.y_shift;
                is_y  = 1'b1;
            end
        endcase
        diff        = {coord[COORD_W-1], coord} - {shift[COORD_W-1], shift};
        prod        = $signed({1'b0, cfg.scale}) * diff;
        mapped_wide = is_y ? ({{13{cfg.y_top[COORD_W-1]}}, cfg.y_top} - {prod[27], prod})
                           : {prod[27], prod};
        mapped      = sat16(mapped_wide);
        dx_sat      = sat16({{13{xe_reg[COORD_W-1]}}, xe_reg} - {{13{xs_reg[COORD_W-1]}}, xs_reg});
        dy_sat      = sat16({{13{ye_reg[COORD_W-1]}}, ye_reg} - {{13{ys_reg[COORD_W-1]}}, ys_reg});
    end

    always_comb
    begin
        dx_ext = {dx_reg[COORD_W-1], dx_reg};
        dy_ext = {dy_reg[COORD_W-1], dy_reg};
        dx_mag = dx_reg[COORD_W-1] ? (17'd0 - dx_ext) : dx_ext;
        dy_mag = dy_reg[COORD_W-1] ? (17'd0 - dy_ext) : dy_ext;
        mag_or = dx_mag | dy_mag;
        bitlen = '0;
        for (int i = 0; i <= COORD_W; i++)
        begin
            if (mag_or[i])
            begin
                bitlen = NB_W'(i + 1);
            end
        end
        if (bitlen == '0)
        begin
            bitlen = 5'd1;
        end
        nb_calc = bitlen + 5'd1;
    end

    always_comb
    begin
        dxv     = {dx_reg[COORD_W-1], dx_reg};
        dyv     = {dy_reg[COORD_W-1], dy_reg};
        len_a   = (nb_reg == 5'd17) ? 4'd1 : 4'd0;
        len_b   = (nb_reg > 5'd16) ? 4'd8 : ((nb_reg > 5'd8) ? 4'(nb_reg - 5'd8) : 4'd0);
        len_c   = (nb_reg >= 5'd8) ? 4'd8 : 4'(nb_reg);
        nbm2    = 4'(nb_reg - 5'd2);
        is_end  = (cur_reg.func == FUNC_END);
        is_line = (cur_reg.func == FUNC_LINE);
        if (is_end)
        begin
            last_idx = IDX_MAIN;
        end
        else if (is_line)
        begin
            last_idx = IDX_LINE_LAST;
        end
        else
        begin
            last_idx = IDX_POINT_LAST;
        end

        unique case (idx_reg)
            6'd0:  seg = mk_seg(SEG_BITS, 4'd8, 8'h00);
            6'd1:  seg = mk_seg(SEG_BITS, 4'd8, 8'h01);
            6'd2:  seg = mk_seg(SEG_BITS, 4'd8, 8'h14);
            6'd3:  seg = mk_seg(SEG_BITS, 4'd8, 8'h00);
            6'd4:  seg = mk_seg(SEG_BITS, 4'd8, 8'h00);
            6'd5:  seg = mk_seg(SEG_BITS, 4'd8, 8'h00);
            6'd6:  seg = mk_seg(SEG_BITS, 4'd8, 8'h00);
            6'd7:  seg = mk_seg(SEG_BITS, 4'd8, 8'hFF);
            6'd8:  seg = mk_seg(SEG_BITS, 4'd8, 8'h01);
            6'd9:  seg = is_end ? mk_seg(SEG_END, 4'd6, 8'h00)
                                : mk_seg(SEG_BITS, 4'd6, 8'h10);
            6'd10: seg = mk_seg(SEG_PAD, 4'd0, 8'h00);
            6'd11: seg = mk_seg(SEG_BITS, 4'd8, 8'h00);
            6'd12: seg = mk_seg(SEG_BITS, 4'd8, 8'h01);
            6'd13: seg = mk_seg(SEG_BITS, 4'd8, 8'h14);
            6'd14: seg = mk_seg(SEG_BITS, 4'd8, 8'h00);
            6'd15: seg = mk_seg(SEG_BITS, 4'd8, cur_reg.red);
            6'd16: seg = mk_seg(SEG_BITS, 4'd8, cur_reg.green);
            6'd17: seg = mk_seg(SEG_BITS, 4'd8, cur_reg.blue);
            6'd18: seg = mk_seg(SEG_BITS, 4'd8, cur_reg.alpha);
            6'd19: seg = mk_seg(SEG_BITS, 4'd8, 8'h01);
            6'd20: seg = mk_seg(SEG_BITS, 4'd6, 8'h09);
            6'd21: seg = mk_seg(SEG_BITS, 4'd5, 8'h0E);
            6'd22: seg = mk_seg(SEG_BITS, 4'd8, xs_reg[13:6]);
            6'd23: seg = mk_seg(SEG_BITS, 4'd6, {2'b00, xs_reg[5:0]});
            6'd24: seg = mk_seg(SEG_BITS, 4'd8, ys_reg[13:6]);
            6'd25: seg = mk_seg(SEG_BITS, 4'd6, {2'b00, ys_reg[5:0]});
            6'd26: seg = mk_seg(SEG_BITS, 4'd1, 8'h01);
            6'd27: seg = is_line ? mk_seg(SEG_BITS, 4'd7, {1'b0, 2'b11, nbm2, 1'b1})
                                 : mk_seg(SEG_BITS, 4'd8, 8'hD1);
            6'd28: seg = is_line ? mk_seg(SEG_BITS, len_a, {7'd0, dxv[16]})
                                 : mk_seg(SEG_BITS, 4'd6, 8'h14);
            6'd29: seg = is_line ? mk_seg(SEG_BITS, len_b, dxv[15:8])
                                 : mk_seg(SEG_BITS, 4'd8, 8'hD0);
            6'd30: seg = is_line ? mk_seg(SEG_BITS, len_c, dxv[7:0])
                                 : mk_seg(SEG_BITS, 4'd6, 8'h14);
            6'd31: seg = is_line ? mk_seg(SEG_BITS, len_a, {7'd0, dyv[16]})
                                 : mk_seg(SEG_BITS, 4'd8, 8'hD1);
            6'd32: seg = is_line ? mk_seg(SEG_BITS, len_b, dyv[15:8])
                                 : mk_seg(SEG_BITS, 4'd6, 8'h2C);
            6'd33: seg = is_line ? mk_seg(SEG_BITS, len_c, dyv[7:0])
                                 : mk_seg(SEG_BITS, 4'd8, 8'hD0);
            6'd34: seg = mk_seg(SEG_BITS, 4'd6, 8'h2C);
            default: seg = mk_seg(SEG_BITS, 4'd0, 8'h00);
        endcase
    end

    assign push = busy_reg && !full;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            buf_reg <= in_item;
        end
        if (load)
        begin
            cur_reg <= buf_reg;
        end
        unique case (ccnt_reg)
            3'd0:    xs_reg <= mapped;
            3'd1:    ys_reg <= mapped;
            3'd2:    xe_reg <= mapped;
            3'd3:    ye_reg <= mapped;
            3'd4:
            begin
                dx_reg <= dx_sat;
                dy_reg <= dy_sat;
            end
            3'd5:    nb_reg <= nb_calc;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg     <= 1'b0;
            busy_reg          <= 1'b0;
            preamble_sent_reg <= 1'b0;
            idx_reg           <= '0;
            ccnt_reg          <= CCNT_DONE;
        end
        else
        begin
            if (take)
            begin
                buf_valid_reg <= 1'b1;
            end
            else if (load)
            begin
                buf_valid_reg <= 1'b0;
            end

            if (load)
            begin
                // drop the unused function code
                busy_reg <= (buf_reg.func != FUNC_NONE);
                idx_reg  <= preamble_sent_reg ? IDX_MAIN : '0;
                ccnt_reg <= '0;
            end
            else
            begin
                if (ccnt_reg != CCNT_DONE)
                begin
                    ccnt_reg <= ccnt_reg + 3'd1;
                end
                if (push)
                begin
                    if (idx_reg == last_idx)
                    begin
                        busy_reg          <= 1'b0;
                        preamble_sent_reg <= !is_end;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 6'd1;
                    end
                end
            end
        end
    end
endmodule

// ----- sv/vsrbp_back.sv -----
// Back end: MSB-first bit packer with a registered byte output.
module vsrbp_back
    import vsrbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  seg_t        head,
    input  logic        empty,
    output logic        pop,
    vsrbp_out_if.source out_ch
);
    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 out_last_reg;
    logic [6:0]           pend_reg;
    logic [2:0]           pcnt_reg;
    logic                 tail_reg;

    logic                 can;
    logic [SEG_LEN_W-1:0] len;
    logic [15:0]          mask16;
    logic [7:0]           dmask;
    logic [15:0]          cat;
    logic [4:0]           tot;
    logic                 byte_done;
    logic [15:0]          shifted;
    logic [2:0]           rem;
    logic [15:0]          rem_mask;
    logic [6:0]           new_pend;
    logic [2:0]           new_pcnt;
    logic [15:0]          tail_wide;

    assign can = !out_valid_reg || out_ch.ready;
    assign pop = can && !tail_reg && !empty;

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.last     = out_last_reg;

    always_comb
    begin
        unique case (head.kind)
            SEG_BITS: len = head.len;
            SEG_PAD:  len = {1'b0, 3'd0 - pcnt_reg};
            SEG_END:  len = 4'd6;
            default:  len = head.len;
        endcase
        mask16    = (16'd1 << len) - 16'd1;
        dmask     = head.data & mask16[7:0];
        cat       = ({9'd0, pend_reg} << len) | {8'd0, dmask};
        tot       = {2'b00, pcnt_reg} + {1'b0, len};
        byte_done = (tot >= 5'd8);
        rem       = tot[2:0];
        shifted   = cat >> rem;
        rem_mask  = (16'd1 << rem) - 16'd1;
        if (byte_done)
        begin
            new_pend = cat[6:0] & rem_mask[6:0];
            new_pcnt = rem;
        end
        else
        begin
            new_pend = cat[6:0];
            new_pcnt = tot[2:0];
        end
        tail_wide = {9'd0, pend_reg} << (5'd8 - {2'b00, pcnt_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_last_reg  <= 1'b0;
            pend_reg      <= '0;
            pcnt_reg      <= '0;
            tail_reg      <= 1'b0;
        end
        else if (can)
        begin
            if (tail_reg)
            begin
                // flush the padded final byte of the shape
                out_valid_reg <= 1'b1;
                out_byte_reg  <= tail_wide[7:0];
                out_last_reg  <= 1'b1;
                pend_reg      <= '0;
                pcnt_reg      <= '0;
                tail_reg      <= 1'b0;
            end
            else if (!empty)
            begin
                out_valid_reg <= byte_done;
                out_byte_reg  <= shifted[7:0];
                out_last_reg  <= (head.kind == SEG_END) && (tot == 5'd8);
                pend_reg      <= new_pend;
                pcnt_reg      <= new_pcnt;
                tail_reg      <= (head.kind == SEG_END) && (tot != 5'd8);
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end
endmodule

// ----- sv/vector_shape_record_bit_packer_top.sv -----
// Throughput: the sequencer issues one bit segment per cycle while the segment queue is
// not full, and the packer emits at most one byte per cycle; the style header is sent
// only for the first primitive of a shape.
// Reset: rst_n clears all control state, the bit accumulator and the configuration
// registers to their defaults; the block accepts input in the first cycle after reset.
module vector_shape_record_bit_packer_top
    import vsrbp_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    vsrbp_in_if.sink              in_ch,
    vsrbp_out_if.source           out_ch
);
    cfg_t cfg_reg;
    seg_t wr_seg;
    seg_t head;
    logic push;
    logic pop;
    logic full;
    logic empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale   <= SCALE_RST;
            cfg_reg.x_shift <= '0;
            cfg_reg.y_shift <= '0;
            cfg_reg.y_top   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCALE:   cfg_reg.scale   <= cfg_data[SCALE_W-1:0];
                CFG_X_SHIFT: cfg_reg.x_shift <= cfg_data;
                CFG_Y_SHIFT: cfg_reg.y_shift <= cfg_data;
                CFG_Y_TOP:   cfg_reg.y_top   <= cfg_data;
                default:     ;
            endcase
        end
    end

    vsrbp_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .in_ch (in_ch),
        .push  (push),
        .seg   (wr_seg),
        .full  (full)
    );

    vsrbp_seg_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_seg (wr_seg),
        .pop    (pop),
        .head   (head),
        .full   (full),
        .empty  (empty)
    );

    vsrbp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .out_ch (out_ch)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("segment pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("segment popped from empty queue");

    a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("queue became full without a push");
`endif
endmodule

// ----- tb/vector_shape_record_bit_packer_top_tb.sv -----
// Self-checking testbench for the vector shape record bit packer: predicted byte stream check.
module vector_shape_record_bit_packer_top_tb;
    import vsrbp_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } packed_byte_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SCALE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    vsrbp_in_if in_ch ();
    vsrbp_out_if out_ch ();

    vector_shape_record_bit_packer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    packed_byte_t byte_q[$];
    int unsigned  mdl_scale;
    int           mdl_x_shift;
    int           mdl_y_shift;
    int           mdl_y_top;
    logic [7:0]   acc_bits;
    int           acc_cnt;
    bit           styles_sent;
    int           gap_pct;
    int           stall_pct;
    int           errors;
    int           idle_cycles;
    int           items_sent;
    int           bytes_seen;

    always #4 clk = ~clk;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_LINE;
        in_ch.x_start = '0;
        in_ch.y_start = '0;
        in_ch.x_end = '0;
        in_ch.y_end = '0;
        in_ch.red = '0;
        in_ch.green = '0;
        in_ch.blue = '0;
        in_ch.alpha = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic int sat16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return int'(v);
    endfunction

    function automatic int edge_width(int d);
        int unsigned m;
        int len;
        m = (d < 0) ? -d : d;
        len = 0;
        while (m != 0)
        begin
            len++;
            m >>= 1;
        end
        if (len == 0)
            len = 1;
        return len + 1;
    endfunction

    function automatic void put_bits(logic [31:0] val, int n);
        packed_byte_t b;
        for (int i = n - 1; i >= 0; i--)
        begin
            acc_bits = {acc_bits[6:0], val[i]};
            acc_cnt++;
            if (acc_cnt == 8)
            begin
                b.data = acc_bits;
                b.last = 1'b0;
                byte_q.insert(byte_q.size(), b);
                acc_bits = '0;
                acc_cnt = 0;
            end
        end
    endfunction

    function automatic void pad_byte();
        if (acc_cnt != 0)
            put_bits(0, 8 - acc_cnt);
    endfunction

    function automatic void put_styles(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                       logic [7:0] a);
        put_bits(0, 8);
        put_bits(1, 8);
        put_bits(20, 8);
        put_bits(0, 8);
        put_bits(r, 8);
        put_bits(g, 8);
        put_bits(b, 8);
        put_bits(a, 8);
        put_bits(0, 4);
        put_bits(1, 4);
    endfunction

    function automatic void put_axis_edge(bit vert, int d);
        int nb;
        nb = edge_width(d);
        put_bits(3, 2);
        put_bits(nb - 2, 4);
        put_bits(0, 1);
        put_bits(vert, 1);
        put_bits(d & ((1 << nb) - 1), nb);
    endfunction

    function automatic void pack_primitive(item_t it);
        int xs, ys, xe, ye, dx, dy, nb;
        if (it.func == FUNC_NONE)
            return;
        if (!styles_sent)
        begin
            put_styles(8'd0, 8'd0, 8'd0, 8'd255);
            styles_sent = 1'b1;
        end
        if (it.func == FUNC_END)
        begin
            put_bits(0, 6);
            pad_byte();
            byte_q[byte_q.size() - 1].last = 1'b1;
            styles_sent = 1'b0;
            return;
        end
        xs = sat16(longint'(mdl_scale) * (longint'(it.x_start) - mdl_x_shift));
        ys = sat16(longint'(mdl_y_top) - longint'(mdl_scale) * (longint'(it.y_start) - mdl_y_shift));
        put_bits(16, 6);
        pad_byte();
        put_styles(it.red, it.green, it.blue, it.alpha);
        put_bits(9, 6);
        put_bits(14, 5);
        put_bits(xs & 32'h3FFF, 14);
        put_bits(ys & 32'h3FFF, 14);
        put_bits(1, 1);
        if (it.func == FUNC_LINE)
        begin
            xe = sat16(longint'(mdl_scale) * (longint'(it.x_end) - mdl_x_shift));
            ye = sat16(longint'(mdl_y_top) - longint'(mdl_scale) * (longint'(it.y_end) - mdl_y_shift));
            dx = sat16(longint'(xe) - xs);
            dy = sat16(longint'(ye) - ys);
            nb = edge_width(dx) > edge_width(dy) ? edge_width(dx) : edge_width(dy);
            put_bits(3, 2);
            put_bits(nb - 2, 4);
            put_bits(1, 1);
            put_bits(dx & ((1 << nb) - 1), nb);
            put_bits(dy & ((1 << nb) - 1), nb);
        end
        else
        begin
            put_axis_edge(1'b1, 20);
            put_axis_edge(1'b0, 20);
            put_axis_edge(1'b1, -20);
            put_axis_edge(1'b0, -20);
        end
    endfunction

    always @(posedge clk)
    begin
        packed_byte_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            bytes_seen++;
            if (byte_q.size() == 0)
            begin
                $error("unexpected byte %02h last %0b", out_ch.out_byte, out_ch.last);
                errors++;
            end
            else
            begin
                e = byte_q.pop_front();
                if (out_ch.out_byte !== e.data)
                begin
                    $error("out_byte expected %02h actual %02h", e.data, out_ch.out_byte);
                    errors++;
                end
                if (out_ch.last !== e.last)
                begin
                    $error("last expected %0b actual %0b", e.last, out_ch.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(item_t it);
        while ($urandom_range(99) < gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func <= it.func;
        in_ch.x_start <= it.x_start;
        in_ch.y_start <= it.y_start;
        in_ch.x_end <= it.x_end;
        in_ch.y_end <= it.y_end;
        in_ch.red <= it.red;
        in_ch.green <= it.green;
        in_ch.blue <= it.blue;
        in_ch.alpha <= it.alpha;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pack_primitive(it);
        items_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (byte_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_SCALE:   mdl_scale = val[SCALE_W-1:0];
            CFG_X_SHIFT: mdl_x_shift = $signed(val);
            CFG_Y_SHIFT: mdl_y_shift = $signed(val);
            CFG_Y_TOP:   mdl_y_top = $signed(val);
            default: ;
        endcase
    endtask

    task automatic set_mapping(int sc, int xsh, int ysh, int ytp);
        drain();
        write_reg(CFG_SCALE, sc);
        write_reg(CFG_X_SHIFT, xsh);
        write_reg(CFG_Y_SHIFT, ysh);
        write_reg(CFG_Y_TOP, ytp);
        cfg_we <= 1'b0;
    endtask

    function automatic item_t make_item(logic [FUNC_W-1:0] f, int xs, int ys, int xe, int ye,
                                        logic [31:0] rgba);
        item_t it;
        it.func = f;
        it.x_start = xs;
        it.y_start = ys;
        it.x_end = xe;
        it.y_end = ye;
        {it.red, it.green, it.blue, it.alpha} = rgba;
        return it;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(3))
            0: return $signed(16'($urandom));
            1: return $urandom_range(64) - 32;
            2: return $urandom_range(1) ? 32767 : -32768;
            default: return $urandom_range(4000) - 2000;
        endcase
    endfunction

    function automatic item_t rand_item(logic [FUNC_W-1:0] f);
        return make_item(f, rand_coord(), rand_coord(), rand_coord(), rand_coord(), $urandom);
    endfunction

    task automatic test_directed();
        send_item(make_item(FUNC_LINE, 0, 0, 0, 0, 32'h00000000));
        send_item(make_item(FUNC_LINE, 32767, 32767, -32768, -32768, 32'hFFFFFFFF));
        send_item(make_item(FUNC_LINE, -32768, -32768, 32767, 32767, 32'hA5A55A5A));
        send_item(make_item(FUNC_POINT, 100, -100, 0, 0, 32'h12345678));
        send_item(make_item(FUNC_NONE, 5, 5, 5, 5, 32'hFFFFFFFF));
        send_item(make_item(FUNC_POINT, 8191, -8192, 0, 0, 32'h80808080));
        send_item(make_item(FUNC_LINE, 1, 1, 2, 3, 32'h01020304));
        send_item(make_item(FUNC_END, 0, 0, 0, 0, 32'h0));
        send_item(make_item(FUNC_END, 0, 0, 0, 0, 32'h0));
        send_item(make_item(FUNC_POINT, -1, -1, 0, 0, 32'h7F7F7F7F));
        send_item(make_item(FUNC_END, 0, 0, 0, 0, 32'h0));
    endtask

    task automatic test_mapping_extremes();
        set_mapping(1023, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_item(make_item(FUNC_LINE, -32768, 32767, 32767, -32768, 32'hC3C3C3C3));
        send_item(make_item(FUNC_POINT, 32767, -32768, 0, 0, 32'h3C3C3C3C));
        send_item(make_item(FUNC_END, 0, 0, 0, 0, 32'h0));
        set_mapping(0, 16'h8000, 16'h7FFF, 16'h8000);
        send_item(make_item(FUNC_LINE, 123, 456, -789, 1011, 32'h11223344));
        send_item(make_item(FUNC_END, 0, 0, 0, 0, 32'h0));
        set_mapping(1, 0, 0, 0);
    endtask

    task automatic run_shapes(int n);
        int k;
        k = 0;
        while (k < n)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_item(rand_item(FUNC_NONE));
                send_item(rand_item(FUNC_LINE));
                k++;
            end
            else
            begin
                repeat ($urandom_range(4))
                begin
                    send_item(rand_item($urandom_range(3) == 0 ? FUNC_POINT : FUNC_LINE));
                    k++;
                end
                send_item(rand_item(FUNC_END));
                k++;
            end
        end
    endtask

    task automatic test_random();
        int pct[4][2] = '{'{0, 0}, '{49, 0}, '{0, 49}, '{9, 9}};
        for (int p = 0; p < 4; p++)
        begin
            gap_pct = pct[p][0];
            stall_pct = pct[p][1];
            set_mapping($urandom_range(1023) % ($urandom_range(1) ? 1024 : 8), $urandom,
                        $urandom, $urandom);
            run_shapes(80);
        end
    endtask

    task automatic test_pause_until_empty();
        gap_pct = 0;
        stall_pct = 30;
        run_shapes(5);
        drain();
        run_shapes(5);
        drain();
    endtask

    initial
    begin
        mdl_scale = 1;
        mdl_x_shift = 0;
        mdl_y_shift = 0;
        mdl_y_top = 0;
        acc_bits = '0;
        acc_cnt = 0;
        styles_sent = 1'b0;
        gap_pct = 0;
        stall_pct = 0;
        errors = 0;
        idle_cycles = 0;
        items_sent = 0;
        bytes_seen = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_mapping_extremes();
        test_random();
        test_pause_until_empty();
        drain();
        $display("Covered %0d primitives (lines, points, end markers, ignored codes) and %0d bytes",
                 items_sent, bytes_seen);
        $display("over mapping extremes and four sender/receiver idling mixes.");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
